// ----- src/imuafp_pkg.sv -----
// Package for the IMU angle frame parser: frame layout constants, status codes
// and the frame record that travels from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps

package imuafp_pkg;

    localparam int RX_CAPACITY_DEF = 33;   // default receive capacity in bytes
    localparam int FRAME_LEN       = 11;   // positions held in the frame store
    localparam int SUM_LEN         = 10;   // bytes covered by the checksum
    localparam int QUEUE_DEPTH     = 2;    // frame records between front and back

    localparam logic [7:0] HEADER_BYTE = 8'h55;
    localparam logic [7:0] ANGLE_TYPE  = 8'h01;

    // Byte positions inside a frame
    localparam int POS_HEADER = 0;
    localparam int POS_TYPE   = 2;
    localparam int POS_ROLL   = 4;
    localparam int POS_PITCH  = 6;
    localparam int POS_YAW    = 8;
    localparam int POS_SUM    = 10;

    typedef enum logic [1:0] {
        ST_UPDATED    = 2'd0,
        ST_BAD_HEADER = 2'd1,
        ST_BAD_SUM    = 2'd2,
        ST_OTHER_TYPE = 2'd3
    } t_status;

    typedef struct packed {
        t_status            status;
        logic signed [15:0] roll_code;
        logic signed [15:0] pitch_code;
        logic signed [15:0] yaw_code;
    } t_frame_rec;

    localparam int REC_W = $bits(t_frame_rec);

endpackage

// ----- src/imuafp_in_if.sv -----
// Input channel of the IMU angle frame parser: byte / line-idle beats.
// No dependencies.
`timescale 1ns / 1ps

interface imuafp_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

// ----- src/imuafp_out_if.sv -----
// Output channel of the IMU angle frame parser: status and held angles.
// Depends on imuafp_pkg.
`timescale 1ns / 1ps

interface imuafp_out_if;
    import imuafp_pkg::*;

    logic               valid;
    logic               ready;
    t_status            status;
    logic signed [15:0] roll_angle;
    logic signed [16:0] pitch_angle;
    logic signed [16:0] yaw_angle;

    modport source (output valid, output status, output roll_angle, output pitch_angle,
                    output yaw_angle, input ready);
    modport sink   (input valid, input status, input roll_angle, input pitch_angle,
                    input yaw_angle, output ready);
endinterface

// ----- src/imuafp_front.sv -----
// Front end of the IMU angle frame parser: captures bytes, keeps a running
// checksum and classifies the frame on line idle. Depends on imuafp_pkg, imuafp_in_if.
`timescale 1ns / 1ps

module imuafp_front #(
    parameter int RX_CAPACITY = imuafp_pkg::RX_CAPACITY_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    imuafp_in_if.sink               i_in,
    input  logic                    i_full,
    output logic                    o_push,
    output imuafp_pkg::t_frame_rec  o_rec
);
    import imuafp_pkg::*;

    localparam int PW = $clog2(RX_CAPACITY + 1);

    logic [PW-1:0] r_pos, n_pos;
    logic [7:0]    r_sum, n_sum;
    logic [7:0]    r_store [FRAME_LEN];
    logic [7:0]    n_store [FRAME_LEN];
    logic          accept;
    t_status       status;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_pos   = r_pos;
        n_sum   = r_sum;
        n_store = r_store;
        o_push  = 1'b0;
        if (accept) begin
            if (!i_in.cmd) begin
                // drop bytes once capacity is reached
                if (r_pos < PW'(RX_CAPACITY)) begin
                    for (int i = 0; i < FRAME_LEN; i++) begin
                        if (r_pos == PW'(i)) begin
                            n_store[i] = i_in.rx_byte;
                        end
                    end
                    if (r_pos < PW'(SUM_LEN)) begin
                        n_sum = r_sum + i_in.rx_byte;
                    end
                    n_pos = r_pos + PW'(1);
                end
            end else begin
                // end of frame: hand off record, clear for the next frame
                o_push = 1'b1;
                n_pos  = '0;
                n_sum  = '0;
                for (int i = 0; i < FRAME_LEN; i++) begin
                    n_store[i] = '0;
                end
            end
        end
    end

    always_comb begin
        priority if (r_store[POS_HEADER] != HEADER_BYTE) begin
            status = ST_BAD_HEADER;
        end else if (r_sum != r_store[POS_SUM]) begin
            status = ST_BAD_SUM;
        end else if (r_store[POS_TYPE] != ANGLE_TYPE) begin
            status = ST_OTHER_TYPE;
        end else begin
            status = ST_UPDATED;
        end
    end

    always_comb begin
        o_rec.status     = status;
        o_rec.roll_code  = {r_store[POS_ROLL + 1], r_store[POS_ROLL]};
        o_rec.pitch_code = {r_store[POS_PITCH + 1], r_store[POS_PITCH]};
        o_rec.yaw_code   = {r_store[POS_YAW + 1], r_store[POS_YAW]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_sum <= '0;
            for (int i = 0; i < FRAME_LEN; i++) begin
                r_store[i] <= '0;
            end
        end else begin
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_store <= n_store;
        end
    end

endmodule

// ----- src/imuafp_fifo.sv -----
// Short register queue between the front and back ends of the parser.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module imuafp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

endmodule

// ----- src/imuafp_back.sv -----
// Back end of the IMU angle frame parser: updates the held angles from
// accepted frames and drives the output register. Depends on imuafp_pkg, imuafp_out_if.
`timescale 1ns / 1ps

module imuafp_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  imuafp_pkg::t_frame_rec  i_rec,
    input  logic                    i_empty,
    input  logic signed [15:0]      i_yaw_offset,
    output logic                    o_pop,
    imuafp_out_if.source            o_out
);
    import imuafp_pkg::*;

    logic               r_valid;
    t_status            r_status;
    logic signed [15:0] r_roll;
    logic signed [16:0] r_pitch, n_pitch;
    logic signed [16:0] r_yaw, n_yaw;

    // take a record whenever the output register is free or being drained
    assign o_pop = !i_empty && (!r_valid || o_out.ready);

    assign n_pitch = -{i_rec.pitch_code[15], i_rec.pitch_code};
    assign n_yaw   = {i_rec.yaw_code[15], i_rec.yaw_code}
                   - {i_yaw_offset[15], i_yaw_offset};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_status <= ST_UPDATED;
            r_roll   <= '0;
            r_pitch  <= '0;
            r_yaw    <= '0;
        end else begin
            if (o_pop) begin
                r_valid  <= 1'b1;
                r_status <= i_rec.status;
                if (i_rec.status == ST_UPDATED) begin
                    r_roll  <= i_rec.roll_code;
                    r_pitch <= n_pitch;
                    r_yaw   <= n_yaw;
                end
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.status      = r_status;
    assign o_out.roll_angle  = r_roll;
    assign o_out.pitch_angle = r_pitch;
    assign o_out.yaw_angle   = r_yaw;

endmodule

// ----- src/imu_angle_frame_parser_unit.sv -----
// IMU angle frame parser, top level. An accepted line-idle beat writes its record into
// the queue, which the output register then loads. Throughput: one input beat per
// cycle while the queue has room, bytes and idle events alike; results drain at one
// per cycle while o_out.ready is high, through a two-entry frame queue and the output
// register. Reset (i_rst_n low, synchronous) clears the frame store, position,
// checksum, held angles, yaw offset and all valid state; no clearing pass is needed.
`timescale 1ns / 1ps

module imu_angle_frame_parser_unit #(
    parameter int RX_CAPACITY = imuafp_pkg::RX_CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic signed [15:0] i_cfg_wdata,
    imuafp_in_if.sink          i_in,
    imuafp_out_if.source       o_out
);
    import imuafp_pkg::*;

    // Yaw reference; the user must write it only while the block is idle (not enforced here)
    logic signed [15:0] r_yaw_offset;

    // Front to queue
    logic       push;
    t_frame_rec front_rec;
    logic       q_full;

    // Queue to back
    logic [REC_W-1:0] q_data;
    t_frame_rec       back_rec;
    logic             q_empty;
    logic             pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw_offset <= '0;
        end else if (i_cfg_we) begin
            r_yaw_offset <= i_cfg_wdata;
        end
    end

    // Front: capture bytes, accumulate checksum, classify the frame on idle
    imuafp_front #(
        .RX_CAPACITY(RX_CAPACITY)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (push),
        .o_rec   (front_rec)
    );

    // Queue: lets the front keep taking beats while the output stalls
    imuafp_fifo #(
        .WIDTH(REC_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_rec),
        .i_pop   (pop),
        .o_data  (q_data),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign back_rec = t_frame_rec'(q_data);

    // Back: update held angles on a good frame, present status and angles
    imuafp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rec        (back_rec),
        .i_empty      (q_empty),
        .i_yaw_offset (r_yaw_offset),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

// ----- src/imuafp_checker.sv -----
// Port-level assertions for the IMU angle frame parser, and the bind that
// attaches them to imu_angle_frame_parser_unit. Needs no package.
`timescale 1ns / 1ps

module imuafp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_in_cmd,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [1:0]         i_status,
    input logic signed [15:0] i_roll,
    input logic signed [16:0] i_pitch,
    input logic signed [16:0] i_yaw
);
    localparam logic signed [16:0] PITCH_MIN = -17'sd32767;
    localparam logic signed [16:0] PITCH_MAX = 17'sd32768;

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // Hold a stalled result beat
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_status) && $stable(i_roll)
            && $stable(i_pitch) && $stable(i_yaw))
        else $error("stalled result changed");

    // Negated pitch stays in its range
    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_pitch >= PITCH_MIN) && (i_pitch <= PITCH_MAX))
        else $error("pitch out of range");

    // An idle beat taken with the output empty shows a result after the queue write and output register load
    a_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_cmd && !i_out_valid |-> ##2 i_out_valid)
        else $error("missing result after idle beat");

endmodule

bind imu_angle_frame_parser_unit imuafp_checker u_imuafp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_cmd    (i_in.cmd),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_roll      (o_out.roll_angle),
    .i_pitch     (o_out.pitch_angle),
    .i_yaw       (o_out.yaw_angle)
);
